// ===== src/tzbt_pkg.sv =====
// ----------------------------------------------------------------------------
// tzbt_pkg
// Shared types, codes and zone geometry for the touch zone button tracker.
// ----------------------------------------------------------------------------
package tzbt_pkg;

    // Event kinds carried in the opcode field.
    localparam logic [1:0] OP_DOWN   = 2'd0;
    localparam logic [1:0] OP_UP     = 2'd1;
    localparam logic [1:0] OP_MOTION = 2'd2;

    // Number of zones that have geometry, and the width of a zone index.
    localparam int GEO_ZONES = 3;
    localparam int ZONE_W    = 2;

    // Aspect ratio register, unsigned Q3.12.
    localparam int          ASPECT_W     = 15;
    localparam logic [14:0] ASPECT_RESET = 15'd7282;

    // Squared hit radius is a 27-bit Q0.32 value.
    localparam int RSQ_W = 27;

    // Geometry of one zone: centre in Q0.16 and hit radius squared.
    typedef struct packed {
        logic [15:0]      cx;
        logic [15:0]      cy;
        logic [RSQ_W-1:0] rsq;
    } tzbt_geo_t;

    // Request from the sequencer to the hit unit.
    typedef struct packed {
        logic              start;
        logic [ZONE_W-1:0] zone;
    } tzbt_hit_req_t;

    // Answer from the hit unit.
    typedef struct packed {
        logic done;
        logic hit;
    } tzbt_hit_rsp_t;

    // Zone geometry table. Radii are the drawn radii enlarged by 1.35.
    function automatic tzbt_geo_t geo_lookup(input logic [ZONE_W-1:0] zone);
        tzbt_geo_t g;
        case (zone)
            2'd0:    g = '{cx: 16'd60621, cy: 16'd41943, rsq: 27'd70644025};
            2'd1:    g = '{cx: 16'd4915,  cy: 16'd41943, rsq: 27'd70644025};
            2'd2:    g = '{cx: 16'd60621, cy: 16'd21627, rsq: 27'd38353249};
            default: g = '{cx: 16'd0,     cy: 16'd0,     rsq: 27'd0};
        endcase
        return g;
    endfunction

endpackage

// ===== src/tzbt_hit_unit.sv =====
// ----------------------------------------------------------------------------
// tzbt_hit_unit
// Circle hit test for one zone on a single shared 32x32 multiplier.
// Four steps: dx = |x-cx|*aspect, dx*dx, dy*dy, then the compare.
// ----------------------------------------------------------------------------
module tzbt_hit_unit
    import tzbt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  tzbt_hit_req_t       req,
    input  logic [15:0]         x,
    input  logic [15:0]         y,
    input  logic [ASPECT_W-1:0] aspect,
    output tzbt_hit_rsp_t       rsp
);

    localparam logic [1:0] PH_DX  = 2'd0;
    localparam logic [1:0] PH_DX2 = 2'd1;
    localparam logic [1:0] PH_DY2 = 2'd2;
    localparam logic [1:0] PH_CMP = 2'd3;

    logic        busy_reg, busy_next;
    logic [1:0]  phase_reg, phase_next;
    logic [30:0] dx_reg;
    logic [61:0] dx2_reg;
    logic [31:0] dy2_reg;

    tzbt_geo_t   geo;
    logic [15:0] adx, ady;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [62:0] lhs, rhs;

    // Geometry and absolute distances for the requested zone.
    always_comb
    begin
        geo = geo_lookup(req.zone);
        adx = (x >= geo.cx) ? (x - geo.cx) : (geo.cx - x);
        ady = (y >= geo.cy) ? (y - geo.cy) : (geo.cy - y);
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (phase_reg)
            PH_DX:
            begin
                mul_a = 32'(adx);
                mul_b = 32'(aspect);
            end
            PH_DX2:
            begin
                mul_a = 32'(dx_reg);
                mul_b = 32'(dx_reg);
            end
            PH_DY2:
            begin
                mul_a = 32'(ady);
                mul_b = 32'(ady);
            end
            PH_CMP:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Final compare in Q.56: dx^2 + (dy^2 << 24) <= r^2 << 24.
    assign lhs = 63'(dx2_reg) + 63'({dy2_reg, 24'd0});
    assign rhs = 63'({geo.rsq, 24'd0});

    assign rsp.done = busy_reg && (phase_reg == PH_CMP);
    assign rsp.hit  = (lhs <= rhs);

    // Step sequencer.
    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next  = 1'b1;
                phase_next = PH_DX;
            end
        end
        else if (phase_reg == PH_CMP)
        begin
            busy_next  = 1'b0;
            phase_next = PH_DX;
        end
        else
        begin
            phase_next = phase_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= PH_DX;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
    end

    // Product registers, one per multiplier step.
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            case (phase_reg)
                PH_DX:   dx_reg  <= prod[30:0];
                PH_DX2:  dx2_reg <= prod[61:0];
                PH_DY2:  dy2_reg <= prod[31:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== src/touch_zone_button_tracker.sv =====
// ----------------------------------------------------------------------------
// touch_zone_button_tracker
// Tracks which finger holds each circular button zone and reports the
// held flags of the gas, brake and boost zones once per touch event.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake             | Beat contents
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_ready   | opcode, finger_id, x_pos, y_pos
//  output   | out_valid / out_ready | gas_held, brake_held, boost_held
//  config   | cfg_valid / cfg_ready | aspect_ratio (Q3.12)
//
// A down or motion beat tests Z = min(NUM_ZONES, 3) zones in turn before it
// reaches the output register; each zone costs a start state plus four steps
// of the shared multiplier. Up beats and unused opcodes go straight to finish.
// The input is taken again as soon as the sequencer is idle, even while a
// result still sits in the output register; a stalled output holds the
// sequencer in its finish state. Reset clears all held flags and loads the
// aspect ratio with about 16/9. Config beats are always taken.
//
module touch_zone_button_tracker
    import tzbt_pkg::*;
#(
    parameter int NUM_ZONES = 3
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic [31:0]         finger_id,
    input  logic [15:0]         x_pos,
    input  logic [15:0]         y_pos,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                gas_held,
    output logic                brake_held,
    output logic                boost_held,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ASPECT_W-1:0] aspect_ratio
);

    localparam int LAST_ZONE = ((NUM_ZONES < GEO_ZONES) ? NUM_ZONES : GEO_ZONES) - 1;
    localparam int PAD_W     = (NUM_ZONES < GEO_ZONES) ? GEO_ZONES : NUM_ZONES;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_START  = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [ZONE_W-1:0]    zone_reg, zone_next;
    logic [ASPECT_W-1:0]  aspect_reg;
    logic [NUM_ZONES-1:0] held_reg, held_next;
    logic [31:0]          owner_reg [NUM_ZONES];
    logic [31:0]          fid_reg;
    logic [15:0]          x_reg, y_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           flags_reg;

    logic                 in_fire;
    logic                 load_out;
    logic [PAD_W-1:0]     held_pad;
    tzbt_hit_req_t        hit_req;
    tzbt_hit_rsp_t        hit_rsp;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign load_out  = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    assign hit_req.start = (state_reg == ST_START);
    assign hit_req.zone  = zone_reg;

    tzbt_hit_unit u_hit
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (hit_req),
        .x      (x_reg),
        .y      (y_reg),
        .aspect (aspect_reg),
        .rsp    (hit_rsp)
    );

    // Event sequencer: release on known opcodes, test zones on down or motion.
    always_comb
    begin
        state_next = state_reg;
        zone_next  = zone_reg;
        held_next  = held_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    zone_next = '0;
                    if (opcode == OP_DOWN || opcode == OP_UP || opcode == OP_MOTION)
                    begin
                        for (int z = 0; z < NUM_ZONES; z++)
                        begin
                            if (owner_reg[z] == finger_id)
                            begin
                                held_next[z] = 1'b0;
                            end
                        end
                    end
                    if (opcode == OP_DOWN || opcode == OP_MOTION)
                    begin
                        state_next = ST_START;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (hit_rsp.done)
                begin
                    for (int z = 0; z < NUM_ZONES; z++)
                    begin
                        if (z < GEO_ZONES && zone_reg == ZONE_W'(z) && hit_rsp.hit)
                        begin
                            held_next[z] = 1'b1;
                        end
                    end
                    if (zone_reg == ZONE_W'(LAST_ZONE))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        zone_next  = zone_reg + 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            zone_reg      <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            aspect_reg    <= ASPECT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            zone_reg      <= zone_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                aspect_reg <= aspect_ratio;
            end
        end
    end

    // Event payload capture.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            fid_reg <= finger_id;
            x_reg   <= x_pos;
            y_reg   <= y_pos;
        end
    end

    // A hit zone takes the finger of the current event as its owner.
    always_ff @(posedge clk)
    begin
        for (int z = 0; z < NUM_ZONES; z++)
        begin
            if (state_reg == ST_WAIT && hit_rsp.done && hit_rsp.hit &&
                z < GEO_ZONES && zone_reg == ZONE_W'(z))
            begin
                owner_reg[z] <= fid_reg;
            end
        end
    end

    // Result flags; zones that do not exist read as not held.
    assign held_pad = PAD_W'(held_reg);

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            flags_reg <= held_pad[2:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign gas_held   = flags_reg[0];
    assign brake_held = flags_reg[1];
    assign boost_held = flags_reg[2];

endmodule

// ===== src/tzbt_checker.sv =====
// ----------------------------------------------------------------------------
// tzbt_checker
// Port-level checks for the touch zone button tracker, bound to the top.
// ----------------------------------------------------------------------------
module tzbt_checker
    import tzbt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [1:0]          opcode,
    input logic [31:0]         finger_id,
    input logic [15:0]         x_pos,
    input logic [15:0]         y_pos,
    input logic                out_valid,
    input logic                out_ready,
    input logic                gas_held,
    input logic                brake_held,
    input logic                boost_held,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [ASPECT_W-1:0] aspect_ratio
);

    // A waiting result beat keeps its flags until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
            $stable(gas_held) && $stable(brake_held) && $stable(boost_held))
    else $error("stalled result beat changed");

    // One event at a time: the input closes right after a beat is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken while an event is in work");

    // A new result only appears while an event is in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
    else $error("result beat with no event in work");

    // Reset empties the output register by the following edge.
    assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid during reset");

endmodule

bind touch_zone_button_tracker tzbt_checker u_tzbt_checker (.*);
